>>> sv/address_region_table_core_assert.svh
// assertion macros for the address region table
`ifndef ADDRESS_REGION_TABLE_CORE_ASSERT_SVH
`define ADDRESS_REGION_TABLE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ART_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ART_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ART_ASSERT_IMPL(label, ante, cons)
`define ART_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/art_pkg.sv
// shared types and constants for the address region table
package art_pkg;
	localparam int MAX_REGIONS = 16;
	localparam int PAGE_BYTES = 4096;
	localparam int ADDR_BITS = 32;
	localparam int IDX_W = $clog2(MAX_REGIONS);
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int PAGE_W = $clog2(PAGE_BYTES);

	localparam logic [1:0] ACT_MAP = 2'd0;
	localparam logic [1:0] ACT_UNMAP = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_RSVD = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOT_MAPPED = 3'd1;
	localparam logic [2:0] ST_LEN_MISMATCH = 3'd2;
	localparam logic [2:0] ST_BAD_ADDR = 3'd3;
	localparam logic [2:0] ST_NO_SPACE = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] addr;
		logic [31:0] len;
	} art_req_t;

	typedef struct packed {
		logic [31:0] result_addr;
		logic [2:0] status;
		logic hit;
		logic [4:0] region_total;
	} art_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_SCAN_RD, S_SCAN, S_WALK_CHK, S_FINISH,
		S_SHIFT_RD, S_SHIFT_WR, S_DONE
	} art_state_t;

	// memory port request from control to the region store
	typedef struct packed {
		logic rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [ADDR_BITS-1:0] wr_start;
		logic [ADDR_BITS-1:0] wr_end;
	} art_mem_req_t;
endpackage

>>> sv/art_region_mem.sv
// region store: one array of start and end pairs, one read and one write port
module art_region_mem import art_pkg::*; (
	input logic clk,
	input art_mem_req_t mreq,
	output logic [ADDR_BITS-1:0] rd_start,
	output logic [ADDR_BITS-1:0] rd_end
);
	logic [2*ADDR_BITS-1:0] mem [MAX_REGIONS];

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_idx] <= {mreq.wr_start, mreq.wr_end};
		end
		if (mreq.rd_en) begin
			{rd_start, rd_end} <= mem[mreq.rd_idx];
		end
	end
endmodule

>>> sv/art_ctrl.sv
// sequencer: scan, gap walk, insert and remove by shifting entries
module art_ctrl import art_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input art_req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output art_rsp_t out_data,
	output art_mem_req_t mreq,
	input logic [ADDR_BITS-1:0] rd_start,
	input logic [ADDR_BITS-1:0] rd_end
);
	art_state_t state_q, state_d;
	logic [ADDR_BITS-1:0] limit_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] act_q;
	logic [ADDR_BITS-1:0] addr_q, len_q, a_q, e_q;
	logic [ADDR_BITS:0] s_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] pos_q;
	logic found_q, bad_q, walk_q;
	logic [ADDR_BITS-1:0] hs_q, he_q;
	art_rsp_t rsp_q;
	logic out_valid_q;

	logic [PAGE_W-1:0] rem;
	logic [ADDR_BITS:0] aligned_hint;
	logic [ADDR_BITS:0] sum_al;
	logic [ADDR_BITS:0] e_al;
	logic scan_end;
	logic scan_hit;
	logic [ADDR_BITS:0] probe;

	assign rem = addr_q[PAGE_W-1:0];
	assign aligned_hint = (rem == '0) ? {1'b0, addr_q} :
		({1'b0, addr_q} + (ADDR_BITS+1)'(PAGE_BYTES) - (ADDR_BITS+1)'(rem));
	assign sum_al = {1'b0, a_q} + {1'b0, len_q};
	assign e_al = (s_q[PAGE_W-1:0] == '0) ? s_q :
		(s_q + (ADDR_BITS+1)'(PAGE_BYTES) - (ADDR_BITS+1)'(s_q[PAGE_W-1:0]));
	assign scan_end = (i_q >= cnt_q);
	assign probe = (act_q == ACT_MAP) ? {1'b0, a_q} : {1'b0, addr_q};
	// during the gap walk the next entry is taken as is, without a search
	assign scan_hit = !scan_end && (walk_q || ({1'b0, rd_end} > probe));

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= 32'h8000_0000;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (state_q == S_DONE) begin
				out_valid_q <= 1'b1;
				cnt_q <= rsp_q.region_total;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					act_q <= in_data.action;
					addr_q <= in_data.addr;
					len_q <= in_data.len;
					rsp_q <= '{result_addr: '0, status: ST_OK, hit: 1'b0,
						region_total: cnt_q};
				end
			end
			S_PREP: begin
				i_q <= '0;
				found_q <= 1'b0;
				walk_q <= 1'b0;
				bad_q <= (act_q == ACT_MAP) && aligned_hint[ADDR_BITS];
				if (act_q == ACT_MAP) begin
					a_q <= aligned_hint[ADDR_BITS-1:0];
				end
			end
			S_SCAN: begin
				// first region ending above probe
				if (scan_hit) begin
					found_q <= 1'b1;
					hs_q <= rd_start;
					he_q <= rd_end;
				end else if (!scan_end) begin
					i_q <= i_q + 1'b1;
				end
			end
			S_WALK_CHK: begin
				s_q <= sum_al;
				if (sum_al > {1'b0, limit_q}) begin
					bad_q <= 1'b1;
				end else if (scan_end || !found_q || sum_al <= {1'b0, hs_q}) begin
					found_q <= 1'b0;
				end else begin
					a_q <= he_q;
					i_q <= i_q + 1'b1;
					walk_q <= 1'b1;
				end
			end
			S_SCAN_RD: begin
				found_q <= 1'b0;
			end
			S_FINISH: begin
				case (act_q)
					ACT_MAP: begin
						if (len_q == '0) begin
							rsp_q.result_addr <= addr_q;
						end else if (bad_q || e_al[ADDR_BITS]) begin
							rsp_q.result_addr <= '1;
							rsp_q.status <= ST_BAD_ADDR;
						end else if (cnt_q >= CNT_W'(MAX_REGIONS)) begin
							rsp_q.result_addr <= '1;
							rsp_q.status <= ST_NO_SPACE;
						end else begin
							rsp_q.result_addr <= a_q;
							rsp_q.region_total <= cnt_q + 1'b1;
							e_q <= e_al[ADDR_BITS-1:0];
							pos_q <= '0;
							i_q <= cnt_q;
						end
					end
					ACT_UNMAP: begin
						s_q <= {1'b0, addr_q} + {1'b0, len_q};
						if (addr_q > limit_q || ({1'b0, addr_q} + {1'b0, len_q}) >
							{1'b0, limit_q}) begin
							rsp_q.status <= ST_BAD_ADDR;
						end else if (!found_q ||
							{1'b0, hs_q} >= ({1'b0, addr_q} + {1'b0, len_q})) begin
							rsp_q.status <= ST_NOT_MAPPED;
						end else if ({1'b0, he_q} >= ({1'b0, addr_q} + {1'b0, len_q})) begin
							rsp_q.region_total <= cnt_q - 1'b1;
							pos_q <= i_q + 1'b1;
						end else begin
							rsp_q.status <= ST_LEN_MISMATCH;
						end
					end
					ACT_LOOKUP: begin
						rsp_q.hit <= found_q && (hs_q <= addr_q);
					end
					default: begin
					end
				endcase
			end
			S_SHIFT_WR: begin
				if (act_q == ACT_MAP) begin
					i_q <= i_q - 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// map insert: entry i-1 moves to i while its start is above a
	logic ins_move;
	assign ins_move = (i_q != '0) && (rd_start > a_q);

	always_comb begin
		state_d = state_q;
		mreq = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) state_d = S_PREP;
			end
			S_PREP: begin
				if (act_q == ACT_MAP && len_q == '0) state_d = S_FINISH;
				else if (act_q == ACT_MAP && aligned_hint[ADDR_BITS]) state_d = S_FINISH;
				else if (act_q == ACT_MAP && aligned_hint[ADDR_BITS-1:0] == '0)
					state_d = S_WALK_CHK;
				else if (act_q inside {ACT_MAP, ACT_UNMAP, ACT_LOOKUP})
					state_d = S_SCAN_RD;
				else state_d = S_FINISH;
			end
			S_SCAN_RD: begin
				mreq.rd_en = 1'b1;
				mreq.rd_idx = i_q[IDX_W-1:0];
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_end || scan_hit) begin
					state_d = (act_q == ACT_MAP) ? S_WALK_CHK : S_FINISH;
				end else begin
					mreq.rd_en = 1'b1;
					mreq.rd_idx = IDX_W'(i_q + 1'b1);
					state_d = S_SCAN;
				end
			end
			S_WALK_CHK: begin
				if (sum_al > {1'b0, limit_q} || bad_q) state_d = S_FINISH;
				else if (scan_end || sum_al <= {1'b0, hs_q} || !found_q) state_d = S_FINISH;
				else state_d = S_SCAN_RD;
			end
			S_FINISH: begin
				state_d = S_DONE;
				if (act_q == ACT_MAP && len_q != '0 && !bad_q && !e_al[ADDR_BITS] &&
					cnt_q < CNT_W'(MAX_REGIONS)) state_d = S_SHIFT_RD;
				if (act_q == ACT_UNMAP && addr_q <= limit_q &&
					({1'b0, addr_q} + {1'b0, len_q}) <= {1'b0, limit_q} && found_q &&
					{1'b0, hs_q} < ({1'b0, addr_q} + {1'b0, len_q}) &&
					{1'b0, he_q} >= ({1'b0, addr_q} + {1'b0, len_q}))
					state_d = S_SHIFT_RD;
			end
			S_SHIFT_RD: begin
				mreq.rd_en = 1'b1;
				if (act_q == ACT_MAP) begin
					mreq.rd_idx = IDX_W'(i_q - 1'b1);
					state_d = S_SHIFT_WR;
				end else if (pos_q >= cnt_q) begin
					state_d = S_DONE;
				end else begin
					mreq.rd_idx = pos_q[IDX_W-1:0];
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				mreq.wr_en = 1'b1;
				if (act_q == ACT_MAP) begin
					if (ins_move) begin
						mreq.wr_idx = i_q[IDX_W-1:0];
						mreq.wr_start = rd_start;
						mreq.wr_end = rd_end;
						state_d = S_SHIFT_RD;
					end else begin
						mreq.wr_idx = i_q[IDX_W-1:0];
						mreq.wr_start = a_q;
						mreq.wr_end = e_q;
						state_d = S_DONE;
					end
				end else begin
					mreq.wr_idx = IDX_W'(pos_q - 1'b1);
					mreq.wr_start = rd_start;
					mreq.wr_end = rd_end;
					state_d = S_SHIFT_RD;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
endmodule

>>> sv/address_region_table_core.sv
// top level of the address region table
// A request is accepted, then scans for the first region ending above the address, walks
// over regions in the map gap walk, and moves entries on insert or removal; every step
// is at most one access to the region memory, which has a registered read. One request is
// worked at a time; a result waits in the output register until taken. Regions live in
// memory undefined after reset; only the count is cleared, so there is no clearing pass.
`include "address_region_table_core_assert.svh"
module address_region_table_core import art_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input art_req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output art_rsp_t out_data
);
	art_mem_req_t mreq;
	logic [ADDR_BITS-1:0] rd_start, rd_end;

	art_ctrl u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data, .mreq, .rd_start, .rd_end
	);

	art_region_mem u_mem (.clk, .mreq, .rd_start, .rd_end);

	`ART_ASSERT_IMPL(a_total_range, out_valid, out_data.region_total <= 5'(MAX_REGIONS))
	`ART_ASSERT_IMPL(a_no_rdwr, mreq.wr_en, !mreq.rd_en)
	`ART_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
endmodule

>>> sim/tb.sv
// testbench for the address region table: directed and random requests checked against a predictor
module tb;
	import art_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	art_req_t in_data;
	logic out_valid;
	logic out_ready;
	art_rsp_t out_data;

	address_region_table_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// predictor state
	logic [32:0] lim;
	logic [31:0] tbl_start [MAX_REGIONS];
	logic [31:0] tbl_end [MAX_REGIONS];
	int tbl_count;
	art_rsp_t rsp_queue [$];
	int fails;
	int cycles;

	initial clk = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// round up to a page; returns 1 on overflow past 32 bits
	function automatic logic page_up(input logic [32:0] x, output logic [32:0] r);
		r = (x + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
		return r[32];
	endfunction

	function automatic int first_above(input logic [32:0] a);
		int i;
		for (i = 0; i < tbl_count; i++)
			if ({1'b0, tbl_end[i]} > a) break;
		return i;
	endfunction

	function automatic art_rsp_t predict_region_op(input art_req_t rq);
		art_rsp_t r;
		logic bad;
		logic [32:0] a, s, e;
		int i, pos;
		r = '0;
		if (rq.action == ACT_MAP) begin
			if (rq.len == 0) begin
				r.result_addr = rq.addr;
			end else begin
				bad = page_up({1'b0, rq.addr}, a);
				s = a + rq.len;
				if (!bad && (s[32] || s > lim)) bad = 1'b1;
				if (!bad && a != 0) begin
					i = first_above(a);
					forever begin
						s = a + rq.len;
						if (s[32] || s > lim) begin
							bad = 1'b1;
							break;
						end
						if (i >= tbl_count || s <= {1'b0, tbl_start[i]}) break;
						a = {1'b0, tbl_end[i]};
						i++;
					end
				end
				if (!bad) begin
					s = a + rq.len;
					if (page_up(s, e)) bad = 1'b1;
				end
				if (bad) begin
					r.result_addr = '1;
					r.status = ST_BAD_ADDR;
				end else if (tbl_count >= MAX_REGIONS) begin
					r.result_addr = '1;
					r.status = ST_NO_SPACE;
				end else begin
					pos = 0;
					while (pos < tbl_count && {1'b0, tbl_start[pos]} <= a) pos++;
					for (int k = tbl_count; k > pos; k--) begin
						tbl_start[k] = tbl_start[k-1];
						tbl_end[k] = tbl_end[k-1];
					end
					tbl_start[pos] = a[31:0];
					tbl_end[pos] = e[31:0];
					tbl_count++;
					r.result_addr = a[31:0];
				end
			end
		end else if (rq.action == ACT_UNMAP) begin
			s = {1'b0, rq.addr} + rq.len;
			if ({1'b0, rq.addr} > lim || s[32] || s > lim) begin
				r.status = ST_BAD_ADDR;
			end else begin
				i = first_above({1'b0, rq.addr});
				if (i >= tbl_count || {1'b0, tbl_start[i]} >= s) begin
					r.status = ST_NOT_MAPPED;
				end else if ({1'b0, tbl_end[i]} >= s) begin
					for (int k = i; k + 1 < tbl_count; k++) begin
						tbl_start[k] = tbl_start[k+1];
						tbl_end[k] = tbl_end[k+1];
					end
					tbl_count--;
				end else begin
					r.status = ST_LEN_MISMATCH;
				end
			end
		end else if (rq.action == ACT_LOOKUP) begin
			i = first_above({1'b0, rq.addr});
			if (i < tbl_count && tbl_start[i] <= rq.addr) r.hit = 1'b1;
		end
		r.region_total = 5'(tbl_count);
		return r;
	endfunction

	// result checker with random stalls
	initial begin
		int stall;
		art_rsp_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(3) == 0 ? 0 : $urandom_range(19);
			repeat (stall) @(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			if (rsp_queue.size() == 0) begin
				$error("result with no request pending");
				fails++;
			end else begin
				want = rsp_queue.pop_front();
				if (out_data.result_addr !== want.result_addr) begin
					$error("result_addr exp %h got %h", want.result_addr, out_data.result_addr);
					fails++;
				end
				if (out_data.status !== want.status) begin
					$error("status exp %0d got %0d", want.status, out_data.status);
					fails++;
				end
				if (out_data.hit !== want.hit) begin
					$error("hit exp %0d got %0d", want.hit, out_data.hit);
					fails++;
				end
				if (out_data.region_total !== want.region_total) begin
					$error("region_total exp %0d got %0d", want.region_total,
						out_data.region_total);
					fails++;
				end
			end
			@(negedge clk);
			out_ready = 1'b0;
		end
	end

	logic burst;

	// valid drops at the start of a gap; with no gap the next request follows at once
	task automatic send_request(input logic [1:0] act, input logic [31:0] ad,
		input logic [31:0] ln);
		int gap;
		art_req_t rq;
		gap = burst ? 0 : $urandom_range(19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rq = '{action: act, addr: ad, len: ln};
		in_data <= rq;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		rsp_queue.push_back(predict_region_op(rq));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (rsp_queue.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic set_limit(input logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		lim = {1'b0, v};
	endtask

	task automatic clear_table();
		while (tbl_count > 0)
			send_request(ACT_UNMAP, tbl_start[0], 32'd1);
	endtask

	task automatic test_directed();
		send_request(ACT_LOOKUP, 32'h0, 32'h0);
		send_request(ACT_MAP, 32'h1234, 32'h0);
		send_request(ACT_MAP, 32'hffff_ffff, 32'h0);
		send_request(ACT_MAP, 32'h0, 32'h1);
		send_request(ACT_MAP, 32'h0, 32'h2000);
		send_request(ACT_MAP, 32'h1001, 32'h1000);
		send_request(ACT_MAP, 32'hffff_f001, 32'h10);
		send_request(ACT_MAP, 32'h1000, 32'hffff_ffff);
		send_request(ACT_MAP, 32'h7fff_f000, 32'h1000);
		send_request(ACT_LOOKUP, 32'h2000, 32'h0);
		send_request(ACT_LOOKUP, 32'hffff_ffff, 32'h0);
		send_request(ACT_UNMAP, 32'h8000_0001, 32'h0);
		send_request(ACT_UNMAP, 32'hffff_ffff, 32'hffff_ffff);
		send_request(ACT_UNMAP, 32'h5000_0000, 32'h10);
		send_request(ACT_UNMAP, 32'h3000, 32'h8000);
		send_request(ACT_UNMAP, 32'h3010, 32'h10);
		send_request(ACT_RSVD, 32'hffff_ffff, 32'hffff_ffff);
		for (int k = 0; k < 17; k++)
			send_request(ACT_MAP, 32'h10_0000, 32'h800);
		clear_table();
	endtask

	task automatic test_limits();
		set_limit(32'hffff_ffff);
		send_request(ACT_MAP, 32'hffff_e000, 32'h1000);
		send_request(ACT_MAP, 32'hffff_e000, 32'h2000);
		send_request(ACT_UNMAP, 32'hffff_e000, 32'h1000);
		send_request(ACT_MAP, 32'hffff_f000, 32'hfff);
		clear_table();
		set_limit(32'h0);
		send_request(ACT_MAP, 32'h0, 32'h1);
		send_request(ACT_MAP, 32'h1000, 32'h1);
		send_request(ACT_UNMAP, 32'h0, 32'h0);
		clear_table();
		set_limit(32'h8000_0000);
	endtask

	function automatic logic [31:0] pick_addr();
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'($urandom_range(64)) << 12;
			2: return (32'($urandom_range(64)) << 12) + 32'($urandom_range(4095));
			3: return (tbl_count > 0) ? tbl_start[$urandom_range(tbl_count - 1)] : 32'h1000;
			default: return (tbl_count > 0) ?
				tbl_end[$urandom_range(tbl_count - 1)] - 32'd1 : $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_len();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h0;
			default: return 32'($urandom_range(1, 5 * PAGE_BYTES));
		endcase
	endfunction

	task automatic test_random(input int n);
		logic [1:0] act;
		int r;
		for (int k = 0; k < n; k++) begin
			if (k % 300 == 150) burst = ~burst;
			r = $urandom_range(99);
			if (r < 45) act = ACT_MAP;
			else if (r < 75) act = ACT_UNMAP;
			else if (r < 97) act = ACT_LOOKUP;
			else act = ACT_RSVD;
			send_request(act, pick_addr(), pick_len());
		end
	endtask

	initial begin
		fails = 0;
		cycles = 0;
		burst = 1'b0;
		lim = 33'h0_8000_0000;
		tbl_count = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_limits();
		test_random(400);
		set_limit(32'h0004_0000);
		test_random(300);
		set_limit($urandom);
		test_random(300);
		set_limit(32'h8000_0000);
		test_random(300);
		drain();
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
